// File: sv/mrq_pkg.sv
`default_nettype none
package mrq_pkg;

  localparam int THREADS = 64;
  localparam int BUCKETS = 4;
  localparam int PRIO_W  = 8;
  localparam int TID_W   = $clog2(THREADS);
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int FILL_W  = $clog2(THREADS + 1);
  localparam int SLOT_AW = BKT_W + TID_W;
  localparam int SLOTS   = BUCKETS * THREADS;
  localparam int OP_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_PICK    = 3'd1,
    OP_STEAL   = 3'd2,
    OP_PREEMPT = 3'd3,
    OP_PEEK    = 3'd4
  } op_t;

  // The bucket of a priority is (prio * BUCKETS) / 256: its top bits.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [PRIO_W-1:0] prio);
    bucket_of = prio[PRIO_W-1 -: BKT_W];
  endfunction

endpackage
`default_nettype wire

// File: sv/mrq_ram.sv
`default_nettype none
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/multilevel_priority_run_queue_top.sv
// Enqueue, check preempt, unknown operations and pops or peeks that find nothing
// register their result when the item is accepted; a pop or peek that finds a
// thread passes through the read state and the slot memory read to its result register.
// A new item is accepted while the result register is empty or being taken, but not
// while a slot memory read for a pop or peek that finds a thread is in flight.
// Reset clears bucket heads, fills, queued flags and the total; the slot memory is
// not cleared, since only filled slots are ever read.
`default_nettype none
module multilevel_priority_run_queue_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mrq_pkg::OP_W-1:0]      in_operation,
  input  wire logic [mrq_pkg::TID_W-1:0]     in_thread_id,
  input  wire logic [mrq_pkg::PRIO_W-1:0]    in_priority_req,
  input  wire logic [mrq_pkg::BKT_W-1:0]     in_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_thread_valid,
  output logic [mrq_pkg::TID_W-1:0]          out_thread,
  output logic                               out_preempt,
  output logic                               out_enqueue_taken,
  output logic [mrq_pkg::FILL_W-1:0]         out_queued_total
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                          state_r, state_nxt;
  logic [mrq_pkg::TID_W-1:0]       head_r [mrq_pkg::BUCKETS];
  logic [mrq_pkg::TID_W-1:0]       head_nxt [mrq_pkg::BUCKETS];
  logic [mrq_pkg::FILL_W-1:0]      fill_r [mrq_pkg::BUCKETS];
  logic [mrq_pkg::FILL_W-1:0]      fill_nxt [mrq_pkg::BUCKETS];
  logic [mrq_pkg::THREADS-1:0]     flags_r, flags_nxt;
  logic [mrq_pkg::FILL_W-1:0]      total_r, total_nxt;
  logic                            pick_r, pick_nxt;
  logic                            pop_r, pop_nxt;
  logic [mrq_pkg::BKT_W-1:0]       sel_r, sel_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            thr_valid_r, thr_valid_nxt;
  logic [mrq_pkg::TID_W-1:0]       thr_r, thr_nxt;
  logic                            pre_r, pre_nxt;
  logic                            taken_r, taken_nxt;
  logic [mrq_pkg::FILL_W-1:0]      qtot_r, qtot_nxt;

  logic                            ram_we;
  logic [mrq_pkg::SLOT_AW-1:0]     ram_waddr, ram_raddr;
  logic [mrq_pkg::TID_W-1:0]       ram_rdata;

  logic [mrq_pkg::BKT_W-1:0]       in_bkt, hi_sel, lo_sel;
  logic                            any_full;
  logic                            above;
  logic [mrq_pkg::FILL_W+mrq_pkg::BKT_W-1:0] fill_sum;

  assign in_ready          = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid         = out_valid_r;
  assign out_thread_valid  = thr_valid_r;
  assign out_thread        = thr_r;
  assign out_preempt       = pre_r;
  assign out_enqueue_taken = taken_r;
  assign out_queued_total  = qtot_r;

  assign in_bkt = mrq_pkg::bucket_of(in_priority_req);

  // Highest, lowest non-empty buckets, any work at all or above in_bkt, and the fill sum.
  always_comb begin
    hi_sel   = '0;
    lo_sel   = '0;
    any_full = 1'b0;
    above    = 1'b0;
    fill_sum = '0;
    for (int b = 0; b < mrq_pkg::BUCKETS; b++) begin
      if (fill_r[b] != '0) begin
        hi_sel   = mrq_pkg::BKT_W'(b);
        any_full = 1'b1;
        if (mrq_pkg::BKT_W'(b) > in_bkt) begin
          above = 1'b1;
        end
      end
      fill_sum = fill_sum + (mrq_pkg::FILL_W + mrq_pkg::BKT_W)'(fill_r[b]);
    end
    for (int b = mrq_pkg::BUCKETS - 1; b >= 0; b--) begin
      if (fill_r[b] != '0) begin
        lo_sel = mrq_pkg::BKT_W'(b);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    flags_nxt     = flags_r;
    total_nxt     = total_r;
    pick_nxt      = pick_r;
    pop_nxt       = pop_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    thr_valid_nxt = thr_valid_r;
    thr_nxt       = thr_r;
    pre_nxt       = pre_r;
    taken_nxt     = taken_r;
    qtot_nxt      = qtot_r;
    ram_we        = 1'b0;
    ram_waddr     = {in_bkt, mrq_pkg::TID_W'(head_r[in_bkt] + fill_r[in_bkt][mrq_pkg::TID_W-1:0])};
    ram_raddr     = {sel_r, head_r[sel_r]};

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_valid_nxt = 1'b1;
          thr_valid_nxt = 1'b0;
          thr_nxt       = '0;
          pre_nxt       = 1'b0;
          taken_nxt     = 1'b0;
          case (in_operation)
            mrq_pkg::OP_ENQUEUE: begin
              if (!flags_r[in_thread_id] &&
                  fill_r[in_bkt] < mrq_pkg::FILL_W'(mrq_pkg::THREADS)) begin
                ram_we             = 1'b1;
                fill_nxt[in_bkt]   = fill_r[in_bkt] + 1'b1;
                flags_nxt[in_thread_id] = 1'b1;
                total_nxt          = total_r + 1'b1;
                taken_nxt          = 1'b1;
              end
            end
            mrq_pkg::OP_PICK: begin
              if (any_full) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                sel_nxt       = hi_sel;
                pick_nxt      = 1'b1;
                pop_nxt       = 1'b1;
                ram_raddr     = {hi_sel, head_r[hi_sel]};
              end
            end
            mrq_pkg::OP_STEAL: begin
              if (any_full) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                sel_nxt       = lo_sel;
                pick_nxt      = 1'b0;
                pop_nxt       = 1'b1;
                ram_raddr     = {lo_sel, mrq_pkg::TID_W'(head_r[lo_sel] +
                                 fill_r[lo_sel][mrq_pkg::TID_W-1:0] - 1'b1)};
              end
            end
            mrq_pkg::OP_PREEMPT: begin
              pre_nxt = above;
            end
            mrq_pkg::OP_PEEK: begin
              if (fill_r[in_level] != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                sel_nxt       = in_level;
                pick_nxt      = 1'b0;
                pop_nxt       = 1'b0;
                ram_raddr     = {in_level, head_r[in_level]};
              end
            end
            default: begin
            end
          endcase
          qtot_nxt = total_nxt;
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        thr_valid_nxt = 1'b1;
        thr_nxt       = ram_rdata;
        if (pop_r) begin
          fill_nxt[sel_r]      = fill_r[sel_r] - 1'b1;
          flags_nxt[ram_rdata] = 1'b0;
          total_nxt            = total_r - 1'b1;
          if (pick_r) begin
            head_nxt[sel_r] = head_r[sel_r] + 1'b1;
          end
        end
        qtot_nxt  = total_nxt;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      total_r     <= '0;
      for (int b = 0; b < mrq_pkg::BUCKETS; b++) begin
        head_r[b] <= '0;
        fill_r[b] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
    end
    pick_r      <= pick_nxt;
    pop_r       <= pop_nxt;
    sel_r       <= sel_nxt;
    thr_valid_r <= thr_valid_nxt;
    thr_r       <= thr_nxt;
    pre_r       <= pre_nxt;
    taken_r     <= taken_nxt;
    qtot_r      <= qtot_nxt;
  end

  mrq_ram #(
    .WIDTH(mrq_pkg::TID_W),
    .DEPTH(mrq_pkg::SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_thread_id),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The result register must be free whenever a memory read is in flight.
  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !out_valid_r) else $error("result register busy during read");

  a_read_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> out_valid_r && thr_valid_r) else $error("read produced no item");

  a_flags_total: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flags_r) == int'(total_r)) else $error("queued flags disagree with total");

  a_fill_total: assert property (@(posedge clk) disable iff (!rst_n)
    fill_sum == (mrq_pkg::FILL_W + mrq_pkg::BKT_W)'(total_r))
    else $error("bucket fills disagree with total");

endmodule
`default_nettype wire

// File: sim/multilevel_priority_run_queue_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
module multilevel_priority_run_queue_top_test;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                       thread_valid;
    logic [mrq_pkg::TID_W-1:0]  thread;
    logic                       preempt;
    logic                       taken;
    logic [mrq_pkg::FILL_W-1:0] total;
  } rq_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [mrq_pkg::OP_W-1:0] in_operation;
  logic [mrq_pkg::TID_W-1:0] in_thread_id;
  logic [mrq_pkg::PRIO_W-1:0] in_priority_req;
  logic [mrq_pkg::BKT_W-1:0] in_level;
  logic out_valid;
  logic out_ready;
  logic out_thread_valid;
  logic [mrq_pkg::TID_W-1:0] out_thread;
  logic out_preempt;
  logic out_enqueue_taken;
  logic [mrq_pkg::FILL_W-1:0] out_queued_total;

  // Shadow copy of the run queue state.
  logic [mrq_pkg::TID_W-1:0]  rq_slot [mrq_pkg::BUCKETS][mrq_pkg::THREADS];
  logic [mrq_pkg::TID_W-1:0]  rq_head [mrq_pkg::BUCKETS];
  logic [mrq_pkg::FILL_W-1:0] rq_fill [mrq_pkg::BUCKETS];
  logic                       rq_queued [mrq_pkg::THREADS];
  logic [mrq_pkg::FILL_W-1:0] rq_total;

  rq_result_t rq_pending[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  multilevel_priority_run_queue_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_thread_id      (in_thread_id),
    .in_priority_req   (in_priority_req),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_thread_valid  (out_thread_valid),
    .out_thread        (out_thread),
    .out_preempt       (out_preempt),
    .out_enqueue_taken (out_enqueue_taken),
    .out_queued_total  (out_queued_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void rq_clear();
    for (int b = 0; b < mrq_pkg::BUCKETS; b++) begin
      rq_head[b] = '0;
      rq_fill[b] = '0;
    end
    for (int t = 0; t < mrq_pkg::THREADS; t++) begin
      rq_queued[t] = 1'b0;
    end
    rq_total = '0;
  endfunction

  // Applies one operation to the shadow state and returns the result it gives.
  function automatic rq_result_t rq_apply(input logic [mrq_pkg::OP_W-1:0] op,
                                          input logic [mrq_pkg::TID_W-1:0] tid,
                                          input logic [mrq_pkg::PRIO_W-1:0] prio,
                                          input logic [mrq_pkg::BKT_W-1:0] lvl);
    rq_result_t r;
    logic [mrq_pkg::BKT_W-1:0] bk;
    logic [mrq_pkg::TID_W-1:0] pos;
    bit found;
    r = '0;
    bk = prio[mrq_pkg::PRIO_W-1 -: mrq_pkg::BKT_W];
    found = 1'b0;
    case (op)
      mrq_pkg::OP_ENQUEUE: begin
        if (!rq_queued[tid]) begin
          // Ring positions wrap naturally at the slot index width.
          pos = rq_head[bk] + rq_fill[bk][mrq_pkg::TID_W-1:0];
          rq_slot[bk][pos] = tid;
          rq_fill[bk]++;
          rq_queued[tid] = 1'b1;
          rq_total++;
          r.taken = 1'b1;
        end
      end
      mrq_pkg::OP_PICK: begin
        for (int b = mrq_pkg::BUCKETS - 1; b >= 0; b--) begin
          if (!found && rq_fill[b] != 0) begin
            found = 1'b1;
            r.thread = rq_slot[b][rq_head[b]];
            rq_head[b]++;
            rq_fill[b]--;
          end
        end
      end
      mrq_pkg::OP_STEAL: begin
        for (int b = 0; b < mrq_pkg::BUCKETS; b++) begin
          if (!found && rq_fill[b] != 0) begin
            found = 1'b1;
            pos = rq_head[b] + rq_fill[b][mrq_pkg::TID_W-1:0] - 1'b1;
            r.thread = rq_slot[b][pos];
            rq_fill[b]--;
          end
        end
      end
      mrq_pkg::OP_PREEMPT: begin
        for (int b = 0; b < mrq_pkg::BUCKETS; b++) begin
          if (b > bk && rq_fill[b] != 0) r.preempt = 1'b1;
        end
      end
      mrq_pkg::OP_PEEK: begin
        if (rq_fill[lvl] != 0) begin
          r.thread_valid = 1'b1;
          r.thread = rq_slot[lvl][rq_head[lvl]];
        end
      end
      default: begin
      end
    endcase
    if (found) begin
      r.thread_valid = 1'b1;
      rq_queued[r.thread] = 1'b0;
      rq_total--;
    end
    r.total = rq_total;
    return r;
  endfunction

  // Returns right after the edge at which the item was accepted.
  task automatic push_op(input logic [mrq_pkg::OP_W-1:0] op,
                         input logic [mrq_pkg::TID_W-1:0] tid,
                         input logic [mrq_pkg::PRIO_W-1:0] prio,
                         input logic [mrq_pkg::BKT_W-1:0] lvl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_thread_id <= tid;
    in_priority_req <= prio;
    in_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rq_pending.push_back(rq_apply(op, tid, prio, lvl));
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rq_pending.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    rq_result_t got;
    rq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.thread_valid = out_thread_valid;
      got.thread = out_thread;
      got.preempt = out_preempt;
      got.taken = out_enqueue_taken;
      got.total = out_queued_total;
      if (rq_pending.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: valid=%0b thread=%0d preempt=%0b taken=%0b total=%0d",
                 $time, got.thread_valid, got.thread, got.preempt, got.taken, got.total);
      end else begin
        want = rq_pending.pop_front();
        if (got !== want) begin
          fail_count++;
          $display({"%0t mismatch: expected valid=%0b thread=%0d preempt=%0b taken=%0b ",
                    "total=%0d, got valid=%0b thread=%0d preempt=%0b taken=%0b total=%0d"},
                   $time, want.thread_valid, want.thread, want.preempt, want.taken,
                   want.total, got.thread_valid, got.thread, got.preempt, got.taken,
                   got.total);
        end
      end
    end
  end

  task automatic test_directed_cases();
    // Everything empty: pops and peeks find nothing.
    push_op(mrq_pkg::OP_PICK, 6'd0, 8'd0, 2'd0);
    push_op(mrq_pkg::OP_STEAL, 6'd63, 8'd255, 2'd3);
    push_op(mrq_pkg::OP_PEEK, 6'd0, 8'd0, 2'd0);
    push_op(mrq_pkg::OP_PEEK, 6'd0, 8'd0, 2'd3);
    push_op(mrq_pkg::OP_PREEMPT, 6'd0, 8'd0, 2'd0);
    // Unknown operation codes change nothing.
    push_op(3'd5, 6'd63, 8'd255, 2'd3);
    push_op(3'd6, 6'd0, 8'd0, 2'd0);
    push_op(3'd7, 6'd42, 8'd170, 2'd2);
    push_op(mrq_pkg::OP_ENQUEUE, 6'd0, 8'd0, 2'd0);
    push_op(mrq_pkg::OP_ENQUEUE, 6'd63, 8'd255, 2'd3);
    // The same id a second time is refused.
    push_op(mrq_pkg::OP_ENQUEUE, 6'd63, 8'd0, 2'd0);
    push_op(mrq_pkg::OP_ENQUEUE, 6'd21, 8'd64, 2'd1);
    push_op(mrq_pkg::OP_ENQUEUE, 6'd42, 8'd191, 2'd2);
    push_op(mrq_pkg::OP_ENQUEUE, 6'd7, 8'd63, 2'd0);
    push_op(mrq_pkg::OP_PREEMPT, 6'd0, 8'd255, 2'd0);
    push_op(mrq_pkg::OP_PREEMPT, 6'd0, 8'd0, 2'd0);
    push_op(mrq_pkg::OP_PREEMPT, 6'd0, 8'd128, 2'd0);
    for (int l = 0; l < mrq_pkg::BUCKETS; l++)
      push_op(mrq_pkg::OP_PEEK, 6'd0, 8'd0, l[mrq_pkg::BKT_W-1:0]);
    push_op(mrq_pkg::OP_PICK, 6'd0, 8'd0, 2'd0);
    push_op(mrq_pkg::OP_STEAL, 6'd0, 8'd0, 2'd0);
    push_op(3'd7, 6'd63, 8'd255, 2'd3);
    push_op(mrq_pkg::OP_PICK, 6'd0, 8'd0, 2'd0);
  endtask

  // Fills one bucket with every id, then makes its ring wrap at both ends.
  task automatic test_ring_wrap();
    for (int i = 0; i < 3; i++) push_op(mrq_pkg::OP_PICK, 6'd0, 8'd0, 2'd0);
    for (int t = 0; t < mrq_pkg::THREADS; t++)
      push_op(mrq_pkg::OP_ENQUEUE, t[mrq_pkg::TID_W-1:0], 8'($urandom_range(191, 128)), 2'd0);
    push_op(mrq_pkg::OP_ENQUEUE, 6'($urandom_range(63)), 8'($urandom_range(255)), 2'd0);
    push_op(mrq_pkg::OP_PREEMPT, 6'd0, 8'd0, 2'd0);
    for (int i = 0; i < 40; i++) push_op(mrq_pkg::OP_PICK, 6'd0, 8'd0, 2'd0);
    for (int t = 0; t < 40; t++)
      push_op(mrq_pkg::OP_ENQUEUE, t[mrq_pkg::TID_W-1:0], 8'($urandom_range(191, 128)), 2'd0);
    push_op(mrq_pkg::OP_PEEK, 6'd0, 8'd0, 2'd2);
    push_op(mrq_pkg::OP_PREEMPT, 6'd0, 8'd200, 2'd0);
    for (int i = 0; i < 10; i++) push_op(mrq_pkg::OP_STEAL, 6'd0, 8'd0, 2'd0);
    for (int i = 0; i < 70; i++) push_op(mrq_pkg::OP_PICK, 6'd0, 8'd0, 2'd0);
  endtask

  // Alternates between filling and draining stretches so the queue level swings.
  task automatic test_random_mix(input int count);
    int roll;
    int enq_weight;
    logic [mrq_pkg::OP_W-1:0] op;
    logic [mrq_pkg::PRIO_W-1:0] prio;
    for (int i = 0; i < count; i++) begin
      enq_weight = ((i / 150) % 2 == 0) ? 65 : 20;
      if ($urandom_range(99) < enq_weight) begin
        op = mrq_pkg::OP_ENQUEUE;
      end else begin
        roll = $urandom_range(99);
        if (roll < 30) op = mrq_pkg::OP_PICK;
        else if (roll < 55) op = mrq_pkg::OP_STEAL;
        else if (roll < 75) op = mrq_pkg::OP_PREEMPT;
        else if (roll < 95) op = mrq_pkg::OP_PEEK;
        else op = mrq_pkg::OP_W'($urandom_range(7, 5));
      end
      if ($urandom_range(9) == 0) prio = $urandom_range(1) ? 8'hFF : 8'h00;
      else prio = mrq_pkg::PRIO_W'($urandom_range(255));
      push_op(op, 6'($urandom_range(63)), prio, 2'($urandom_range(3)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_thread_id = '0;
    in_priority_req = '0;
    in_level = '0;
    out_ready = 1'b0;
    rq_clear();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 80;
    test_directed_cases();
    test_ring_wrap();
    test_random_mix(350);
    idle_until_drained();

    send_idle_pct = 80;
    recv_idle_pct = 9;
    test_random_mix(350);
    idle_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(350);

    idle_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
